[hw/rtl/ulw_pkg.sv]
package ulw_pkg;

   // event codes
   localparam logic [2:0] FUNC_FRAME = 3'd0;
   localparam logic [2:0] FUNC_FAIL  = 3'd1;
   localparam logic [2:0] FUNC_OK    = 3'd2;
   localparam logic [2:0] FUNC_CHECK = 3'd3;
   localparam logic [2:0] FUNC_FORCE = 3'd4;

   // recovery causes
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
   localparam logic [1:0] CAUSE_FAILS   = 2'd2;
   localparam logic [1:0] CAUSE_FORCED  = 2'd3;

   // csr indexes
   localparam logic [1:0] CSR_FRAME_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_FAIL_THRESH   = 2'd1;
   localparam logic [1:0] CSR_BACKOFF       = 2'd2;

   // csr reset values
   localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd500;
   localparam logic [15:0] FAIL_THRESH_RST   = 16'd10;
   localparam logic [15:0] BACKOFF_RST       = 16'd2000;

   localparam logic [15:0] FAIL_COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] frame_timeout_ms;
      logic [15:0] fail_threshold;
      logic [15:0] backoff_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] last_frame_ms;
      logic [15:0] fail_count;
      logic        frame_seen;
      logic [31:0] last_recover_ms;
      logic [31:0] recoveries;
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] now_ms;
      logic        device_configured;
   } event_type;

   typedef struct packed {
      logic        recover_start;
      logic [1:0]  cause;
      logic        throttled;
      logic [31:0] recover_count;
   } result_type;

endpackage

[hw/rtl/ulw_req_if.sv]
interface ulw_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] now_ms;
   logic        device_configured;

   modport source (output valid, output func, output now_ms, output device_configured,
                   input ready);
   modport sink   (input valid, input func, input now_ms, input device_configured,
                   output ready);
endinterface

[hw/rtl/ulw_rsp_if.sv]
interface ulw_rsp_if;
   logic        valid;
   logic        ready;
   logic        recover_start;
   logic [1:0]  cause;
   logic        throttled;
   logic [31:0] recover_count;

   modport source (output valid, output recover_start, output cause, output throttled,
                   output recover_count, input ready);
   modport sink   (input valid, input recover_start, input cause, input throttled,
                   input recover_count, output ready);
endinterface

[hw/rtl/ulw_eval.sv]
module ulw_eval
   import ulw_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  st,
   input  event_type  evt,
   output state_type  st_nxt,
   output result_type res
);

   logic [31:0] frame_gap;
   logic [31:0] recover_gap;
   logic        stamp_behind;
   logic        in_backoff;
   logic [1:0]  cause;
   logic        start;

   // elapsed times since the frame stamp and since the last recovery
   assign frame_gap    = evt.now_ms - st.last_frame_ms;
   assign stamp_behind = evt.now_ms >= st.last_frame_ms;
   assign recover_gap  = evt.now_ms - st.last_recover_ms;
   assign in_backoff   = (st.last_recover_ms != '0) &&
                         (recover_gap < {16'd0, cfg.backoff_ms});

   // per-event update and recovery request
   always_comb begin
      st_nxt = st;
      cause  = CAUSE_NONE;
      case (evt.func)
         FUNC_FRAME: begin
            st_nxt.last_frame_ms = evt.now_ms;
            st_nxt.frame_seen    = 1'b1;
         end
         FUNC_FAIL: begin
            if (st.fail_count != FAIL_COUNT_MAX) begin
               st_nxt.fail_count = st.fail_count + 16'd1;
            end
         end
         FUNC_OK: begin
            st_nxt.fail_count = '0;
         end
         FUNC_CHECK: begin
            if (!evt.device_configured) begin
               st_nxt.last_frame_ms = evt.now_ms;
               st_nxt.fail_count    = '0;
            end else begin
               if (!st.frame_seen) begin
                  st_nxt.last_frame_ms = evt.now_ms;
               end else if (stamp_behind && (frame_gap > {16'd0, cfg.frame_timeout_ms})) begin
                  cause = CAUSE_TIMEOUT;
               end
               if ((cause == CAUSE_NONE) && (st.fail_count >= cfg.fail_threshold)) begin
                  cause = CAUSE_FAILS;
               end
            end
         end
         FUNC_FORCE: begin
            cause = CAUSE_FORCED;
         end
         default: begin
         end
      endcase

      // recovery unless backoff holds it off
      start = (cause != CAUSE_NONE) && !in_backoff;
      if (start) begin
         st_nxt.last_recover_ms = evt.now_ms;
         st_nxt.recoveries      = st.recoveries + 32'd1;
         st_nxt.last_frame_ms   = evt.now_ms;
         st_nxt.fail_count      = '0;
         st_nxt.frame_seen      = 1'b0;
      end

      res.recover_start = start;
      res.cause         = cause;
      res.throttled     = (cause != CAUSE_NONE) && in_backoff;
      res.recover_count = st_nxt.recoveries;
   end

endmodule

[hw/rtl/usb_link_lockup_watchdog.sv]
// the response to an accepted request beat is registered, valid in the next cycle
// one event per cycle while no held response stalls requests; the watchdog state
// updates in a single pass of compare logic between the state registers and the response register
// reset: synchronous, active high; clears all watchdog state and the response
// valid, and loads the timeout, threshold and backoff registers with defaults
module usb_link_lockup_watchdog
   import ulw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   ulw_req_if.sink     req_chan,
   ulw_rsp_if.source   rsp_chan
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   event_type  evt;
   state_type  state_nxt;
   logic       req_fire;

   // take a beat whenever the response register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign evt.func              = req_chan.func;
   assign evt.now_ms            = req_chan.now_ms;
   assign evt.device_configured = req_chan.device_configured;

   ulw_eval u_eval (
      .cfg    (cfg_ff),
      .st     (state_ff),
      .evt    (evt),
      .st_nxt (state_nxt),
      .res    (rsp_in)
   );

   // csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_TIMEOUT: cfg_in.frame_timeout_ms = csr_wr_data;
            CSR_FAIL_THRESH:   cfg_in.fail_threshold   = csr_wr_data;
            CSR_BACKOFF:       cfg_in.backoff_ms       = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // state and response valid
   assign state_in     = req_fire ? state_nxt : state_ff;
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_timeout_ms <= FRAME_TIMEOUT_RST;
         cfg_ff.fail_threshold   <= FAIL_THRESH_RST;
         cfg_ff.backoff_ms       <= BACKOFF_RST;
         state_ff                <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.recover_start = rsp_ff.recover_start;
   assign rsp_chan.cause         = rsp_ff.cause;
   assign rsp_chan.throttled     = rsp_ff.throttled;
   assign rsp_chan.recover_count = rsp_ff.recover_count;

endmodule
